/* hdl/strip_fan_triangle_assembler_defines.svh */
// Assertion helpers shared by the block's modules.
`ifndef STRIP_FAN_TRIANGLE_ASSEMBLER_DEFINES_SVH
`define STRIP_FAN_TRIANGLE_ASSEMBLER_DEFINES_SVH

// same-cycle implication
`define SFTA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfta assertion failed");

// next-cycle implication
`define SFTA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sfta assertion failed");

`endif

/* hdl/sfta_pkg.sv */
package sfta_pkg;

	typedef struct packed {
		logic signed [15:0] v;
		logic signed [15:0] u;
		logic [14:0]        nrm;
		logic [14:0]        vtx;
	} corner_t;

	typedef struct packed {
		corner_t [2:0] c;
	} tri_t;

	typedef struct packed {
		logic full;
		logic empty;
	} tq_status_t;

	localparam int TQ_DEPTH = 2;
	localparam int TQ_AW    = $clog2(TQ_DEPTH);

	localparam logic [1:0] REG_VTOTAL = 2'd0;
	localparam logic [1:0] REG_NTOTAL = 2'd1;
	localparam logic [1:0] REG_OLIMIT = 2'd2;

	localparam logic [14:0] VTOTAL_RST = 15'd2048;
	localparam logic [14:0] NTOTAL_RST = 15'd2048;
	localparam logic [15:0] OLIMIT_RST = 16'd32768;

	localparam logic [16:0] TRI_CORNERS = 17'd3;
	localparam logic [16:0] STOP_MARGIN = 17'd100;

endpackage

/* hdl/strip_fan_triangle_assembler.sv */
// Takes one command word per cycle (full only rises when the triangle queue backs up).
// A triangle is queued on its vertex's last word and loaded into the corner register before
// its first corner reaches the result ports. While pop is held the corner serializer
// gives one corner per cycle; a vertex needs 4 words, so at most 3 corners per 4 words,
// and two triangles of queue absorb short output stalls. arst_n clears control state and
// loads the register reset values; after a stop only reset restarts the stream.
module strip_fan_triangle_assembler
	import sfta_pkg::*;
#(
	parameter int MAX_PRIMITIVE_VERTICES = 50
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] word,
	output logic               empty,
	input  logic               pop,
	output logic [14:0]        vtx_idx,
	output logic [14:0]        nrm_idx,
	output logic signed [15:0] tex_u,
	output logic signed [15:0] tex_v,
	output logic               last
);

	logic       tri_push, take;
	tri_t       tri_data, head;
	tq_status_t tq;

	assign full = tq.full;

	sfta_front #(
		.MAX_PRIMITIVE_VERTICES(MAX_PRIMITIVE_VERTICES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (push && !tq.full),
		.word     (word),
		.tri_push (tri_push),
		.tri_data (tri_data)
	);

	sfta_tri_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (tri_push),
		.wdata (tri_data),
		.take  (take),
		.rdata (head),
		.status(tq)
	);

	sfta_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.tq     (tq),
		.take   (take),
		.pop    (pop),
		.empty  (empty),
		.vtx_idx(vtx_idx),
		.nrm_idx(nrm_idx),
		.tex_u  (tex_u),
		.tex_v  (tex_v),
		.last   (last)
	);

endmodule

/* hdl/sfta_front.sv */
module sfta_front
	import sfta_pkg::*;
#(
	parameter int MAX_PRIMITIVE_VERTICES = 50
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               accept,
	input  logic signed [15:0] word,
	output logic               tri_push,
	output tri_t               tri_data
);

	localparam logic [1:0] PH_CMD  = 2'd0;
	localparam logic [1:0] PH_VTX  = 2'd1;
	localparam logic [1:0] PH_SKIP = 2'd2;
	localparam logic [15:0] MAXV = 16'(MAX_PRIMITIVE_VERTICES);

	logic [14:0] vtot_q, ntot_q;
	logic [15:0] olim_q;
	logic [1:0]  phase_q;
	logic        fan_q;
	logic [5:0]  vleft_q;
	logic [5:0]  vnum_q;
	logic [1:0]  wiv_q;
	logic [17:0] skip_q;
	logic [15:0] emit_q;
	logic        halt_q;
	corner_t     h0_q, h1_q, cur_q;

	logic        live;
	logic [15:0] mag;
	logic [14:0] vtx_cl, nrm_cl;
	corner_t     done_c;
	logic        vtx_end, room, emit;
	logic [15:0] emit_nx;

	assign live    = accept && !halt_q;
	assign mag     = word[15] ? (~word + 16'd1) : word;
	assign vtx_cl  = (word[15] || word[14:0] >= vtot_q) ? 15'd0 : word[14:0];
	assign nrm_cl  = (word[15] || word[14:0] >= ntot_q) ? 15'd0 : word[14:0];
	assign vtx_end = live && (phase_q == PH_VTX) && (wiv_q == 2'd3);
	assign room    = ({1'b0, emit_q} + TRI_CORNERS) < {1'b0, olim_q};
	assign emit    = vtx_end && (vnum_q >= 6'd2) && room;
	assign emit_nx = emit ? (emit_q + 16'd3) : emit_q;

	always_comb begin
		done_c   = cur_q;
		done_c.v = word;
	end

	// strip odd vertices swap the first two corners to keep winding
	always_comb begin
		tri_push = emit;
		tri_data.c[2] = done_c;
		if (!fan_q && vnum_q[0]) begin
			tri_data.c[0] = h1_q;
			tri_data.c[1] = h0_q;
		end else begin
			tri_data.c[0] = h0_q;
			tri_data.c[1] = h1_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vtot_q <= VTOTAL_RST;
			ntot_q <= NTOTAL_RST;
			olim_q <= OLIMIT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_VTOTAL: vtot_q <= cfg_data[14:0];
				REG_NTOTAL: ntot_q <= cfg_data[14:0];
				REG_OLIMIT: olim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (live && phase_q == PH_VTX) begin
			case (wiv_q)
				2'd0: cur_q.vtx <= vtx_cl;
				2'd1: cur_q.nrm <= nrm_cl;
				2'd2: cur_q.u   <= word;
				default: begin
					cur_q.v <= word;
					if (vnum_q == 6'd0) begin
						h0_q <= done_c;
					end else if (vnum_q == 6'd1 || fan_q) begin
						h1_q <= done_c;
					end else begin
						h0_q <= h1_q;
						h1_q <= done_c;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CMD;
			fan_q   <= 1'b0;
			vleft_q <= '0;
			vnum_q  <= '0;
			wiv_q   <= '0;
			skip_q  <= '0;
			emit_q  <= '0;
			halt_q  <= 1'b0;
		end else if (live) begin
			case (phase_q)
				PH_SKIP: begin
					if (skip_q <= 18'd1) begin
						skip_q  <= '0;
						phase_q <= PH_CMD;
					end else begin
						skip_q <= skip_q - 18'd1;
					end
				end
				PH_VTX: begin
					wiv_q <= wiv_q + 2'd1;
					if (wiv_q == 2'd3) begin
						emit_q <= emit_nx;
						vnum_q <= vnum_q + 6'd1;
						if (vleft_q <= 6'd1) begin
							vleft_q <= '0;
							phase_q <= PH_CMD;
							if (({1'b0, emit_nx} + STOP_MARGIN) > {1'b0, olim_q})
								halt_q <= 1'b1;
						end else begin
							vleft_q <= vleft_q - 6'd1;
						end
					end
				end
				default: begin
					phase_q <= PH_CMD;
					if (word != 16'sd0) begin
						fan_q <= word[15];
						if (mag < 16'd3 || mag > MAXV) begin
							skip_q  <= {mag, 2'b00};
							phase_q <= PH_SKIP;
						end else begin
							vleft_q <= mag[5:0];
							vnum_q  <= '0;
							wiv_q   <= '0;
							phase_q <= PH_VTX;
						end
					end
				end
			endcase
		end
	end

endmodule

/* hdl/sfta_tri_queue.sv */
`include "strip_fan_triangle_assembler_defines.svh"

module sfta_tri_queue
	import sfta_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  tri_t       wdata,
	input  logic       take,
	output tri_t       rdata,
	output tq_status_t status
);

	tri_t             mem_q [TQ_DEPTH];
	logic [TQ_AW-1:0] wp_q, rp_q;
	logic [TQ_AW:0]   cnt_q;
	logic             do_take;

	assign status.full  = (cnt_q == (TQ_AW+1)'(TQ_DEPTH));
	assign status.empty = (cnt_q == '0);
	assign do_take      = take && !status.empty;
	assign rdata        = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == TQ_AW'(TQ_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (do_take)
				rp_q <= (rp_q == TQ_AW'(TQ_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			case ({push, do_take})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	`SFTA_ASSERT_NOW(a_tq_no_overflow, push, !status.full)
	`SFTA_ASSERT_NOW(a_tq_cnt_bound, 1'b1, cnt_q <= (TQ_AW+1)'(TQ_DEPTH))

endmodule

/* hdl/sfta_back.sv */
`include "strip_fan_triangle_assembler_defines.svh"

module sfta_back
	import sfta_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  tri_t              head,
	input  tq_status_t        tq,
	output logic              take,
	input  logic              pop,
	output logic              empty,
	output logic [14:0]       vtx_idx,
	output logic [14:0]       nrm_idx,
	output logic signed [15:0] tex_u,
	output logic signed [15:0] tex_v,
	output logic              last
);

	tri_t       cur_q;
	logic [1:0] cnt_q;
	logic       valid_q;
	logic       pop_ok, free;
	corner_t    sel;

	assign pop_ok = pop && valid_q;
	assign free   = !valid_q || (pop_ok && cnt_q == 2'd2);
	assign take   = free && !tq.empty;
	assign empty  = !valid_q;

	always_comb begin
		case (cnt_q)
			2'd0:    sel = cur_q.c[0];
			2'd1:    sel = cur_q.c[1];
			default: sel = cur_q.c[2];
		endcase
	end

	assign vtx_idx = sel.vtx;
	assign nrm_idx = sel.nrm;
	assign tex_u   = sel.u;
	assign tex_v   = sel.v;
	assign last    = (cnt_q == 2'd2);

	always_ff @(posedge clk) begin
		if (take)
			cur_q <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			valid_q <= 1'b0;
		end else if (take) begin
			cnt_q   <= '0;
			valid_q <= 1'b1;
		end else if (free) begin
			valid_q <= 1'b0;
		end else if (pop_ok) begin
			cnt_q <= cnt_q + 2'd1;
		end
	end

	`SFTA_ASSERT_NOW(a_bk_corner_range, valid_q, cnt_q != 2'd3)
	`SFTA_ASSERT_NEXT(a_bk_drain, pop_ok && cnt_q == 2'd2 && tq.empty, !valid_q)

endmodule
